>>> sv/ffa_pkg.sv
// Shared types and constants of the first-fit aligned region allocator.
// Used by the interfaces, the extent cells, the controller and the top level.
package ffa_pkg;

  localparam int MAX_EXTENTS = 32;
  localparam int OFFSET_BITS = 16;
  localparam int SIZE_BITS   = 17;
  localparam int REGION_BITS = 17;
  localparam int ALIGN_BITS  = 4;
  localparam int MASK_BITS   = (1 << ALIGN_BITS) - 1;
  localparam int CALC_BITS   = (OFFSET_BITS > SIZE_BITS ? OFFSET_BITS : SIZE_BITS) + 2;

  localparam logic [CALC_BITS-1:0]   OFF_LIMIT    = CALC_BITS'(64'd1 << OFFSET_BITS);
  localparam logic [REGION_BITS-1:0] REGION_RESET = REGION_BITS'(4096);

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_SPACE   = 2'd1,
    ST_TABLE_FULL = 2'd2,
    ST_NOT_FOUND  = 2'd3
  } status_t;

  typedef struct packed {
    op_t                    op;
    logic [SIZE_BITS-1:0]   size;
    logic [MASK_BITS-1:0]   mask;
    logic [OFFSET_BITS-1:0] free_off;
    logic [CALC_BITS-1:0]   region_lim;
  } bcast_t;

  typedef struct packed {
    logic                   valid;
    logic [OFFSET_BITS-1:0] off;
    logic [SIZE_BITS-1:0]   sz;
  } entry_t;

  typedef struct packed {
    logic                   active;
    logic                   done;
    logic                   del;
    status_t                status;
    logic [OFFSET_BITS-1:0] result;
    logic [CALC_BITS-1:0]   run;
    entry_t                 carry;
  } pkt_t;

  typedef struct packed {
    logic valid;
    logic tok;
  } cell_stat_t;

endpackage

>>> sv/ffa_intf.sv
// Request and result channel interfaces of the allocator.
// Depends on ffa_pkg for the field widths.
interface ffa_req_if;
  logic                           valid;
  logic                           ready;
  logic [0:0]                     operation;
  logic [ffa_pkg::SIZE_BITS-1:0]  req_size;
  logic [ffa_pkg::ALIGN_BITS-1:0] align_log2;
  logic [ffa_pkg::OFFSET_BITS-1:0] free_offset;

  modport source (output valid, output operation, output req_size, output align_log2,
                  output free_offset, input ready);
  modport sink (input valid, input operation, input req_size, input align_log2,
                input free_offset, output ready);
endinterface

interface ffa_res_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      status;
  logic [ffa_pkg::OFFSET_BITS-1:0] result_offset;

  modport source (output valid, output status, output result_offset, input ready);
  modport sink (input valid, input status, input result_offset, output ready);
endinterface

>>> sv/ffa_cell.sv
// One extent cell: holds one table entry and tests it as the walk token passes.
// Depends on ffa_pkg.
module ffa_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  ffa_pkg::bcast_t     bcast,
  input  ffa_pkg::pkt_t       pkt_i,
  output ffa_pkg::pkt_t       pkt_o,
  input  ffa_pkg::entry_t     entry_i,
  output ffa_pkg::entry_t     entry_o,
  output ffa_pkg::cell_stat_t stat_o
);
  import ffa_pkg::*;

  pkt_t   pkt_r;
  entry_t entry_r, entry_nxt;
  logic   pend_r, pend_nxt;

  logic [CALC_BITS-1:0] start, pad, need, at, gap;
  logic                 fits, ovf;

  always_comb begin
    start = entry_r.valid ? CALC_BITS'(entry_r.off) : bcast.region_lim;
    pad   = (~pkt_r.run + CALC_BITS'(1)) & CALC_BITS'(bcast.mask);
    need  = CALC_BITS'(bcast.size) + pad;
    at    = pkt_r.run + pad;
    gap   = start - pkt_r.run;
    fits  = (start >= pkt_r.run) && (gap >= need);
    ovf   = at >= OFF_LIMIT;
  end

  always_comb begin
    pkt_o     = pkt_r;
    entry_nxt = entry_r;
    pend_nxt  = 1'b0;
    if (pend_r) begin
      entry_nxt = entry_i;
    end
    if (pkt_r.active) begin
      if (pkt_r.done) begin
        if (pkt_r.carry.valid) begin
          entry_nxt   = pkt_r.carry;
          pkt_o.carry = entry_r;
        end
        if (pkt_r.del) begin
          pend_nxt = 1'b1;
        end
      end else if (bcast.op == OP_ALLOC) begin
        if (!entry_r.valid || fits) begin
          pkt_o.done = 1'b1;
          if (fits && !ovf) begin
            pkt_o.status = ST_OK;
            pkt_o.result = at[OFFSET_BITS-1:0];
            pkt_o.carry  = entry_r;
            entry_nxt    = '{valid: 1'b1, off: at[OFFSET_BITS-1:0], sz: bcast.size};
          end else begin
            pkt_o.status = ST_NO_SPACE;
          end
        end else begin
          pkt_o.run = start + CALC_BITS'(entry_r.sz);
        end
      end else begin
        if (!entry_r.valid) begin
          pkt_o.done   = 1'b1;
          pkt_o.status = ST_NOT_FOUND;
        end else if (entry_r.off == bcast.free_off && entry_r.sz == bcast.size) begin
          pkt_o.done   = 1'b1;
          pkt_o.status = ST_OK;
          pkt_o.del    = 1'b1;
          pend_nxt     = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pkt_r         <= '0;
      pend_r        <= 1'b0;
      entry_r.valid <= 1'b0;
    end else begin
      pkt_r         <= pkt_i;
      pend_r        <= pend_nxt;
      entry_r.valid <= entry_nxt.valid;
    end
    entry_r.off <= entry_nxt.off;
    entry_r.sz  <= entry_nxt.sz;
  end

  assign entry_o = entry_r;
  assign stat_o  = '{valid: entry_r.valid, tok: pkt_r.active};

endmodule

>>> sv/ffa_ctrl.sv
// Controller: takes requests, launches the walk token into the cell chain and
// registers the result. Depends on ffa_pkg and the channel interfaces.
module ffa_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  ffa_req_if.sink                           in_req,
  ffa_res_if.source                         out_res,
  input  logic                              cfg_wr_en,
  input  logic [ffa_pkg::REGION_BITS-1:0]   cfg_wr_data,
  input  logic                              table_full,
  input  ffa_pkg::pkt_t                     tail_i,
  output ffa_pkg::pkt_t                     launch_o,
  output ffa_pkg::bcast_t                   bcast_o
);
  import ffa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LAUNCH,
    S_WAIT
  } state_t;

  state_t                   state_r;
  op_t                      op_r;
  logic [SIZE_BITS-1:0]     size_r;
  logic [ALIGN_BITS-1:0]    align_r;
  logic [OFFSET_BITS-1:0]   free_off_r;
  logic [REGION_BITS-1:0]   region_r;
  logic                     out_valid_r;
  status_t                  status_r;
  logic [OFFSET_BITS-1:0]   result_r;

  logic                     slot_free, go;
  logic [MASK_BITS:0]       one_sh;

  assign slot_free = !out_valid_r || out_res.ready;
  assign go        = (state_r == S_LAUNCH) && slot_free;
  assign one_sh    = (MASK_BITS+1)'(1) << align_r;

  always_comb begin
    bcast_o.op         = op_r;
    bcast_o.size       = size_r;
    bcast_o.mask       = MASK_BITS'(one_sh - (MASK_BITS+1)'(1));
    bcast_o.free_off   = free_off_r;
    bcast_o.region_lim = (CALC_BITS'(region_r) > OFF_LIMIT) ? OFF_LIMIT
                                                            : CALC_BITS'(region_r);
  end

  always_comb begin
    launch_o        = '0;
    launch_o.active = go;
    launch_o.status = ST_OK;
    if (op_r == OP_ALLOC && table_full) begin
      launch_o.done   = 1'b1;
      launch_o.status = ST_TABLE_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      region_r    <= REGION_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        region_r <= cfg_wr_data;
      end
      if (out_valid_r && out_res.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_req.valid) begin
            state_r <= S_LAUNCH;
          end
        end
        S_LAUNCH: begin
          if (go) begin
            state_r <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (tail_i.active) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
    if (state_r == S_IDLE && in_req.valid) begin
      op_r       <= op_t'(in_req.operation);
      size_r     <= in_req.req_size;
      align_r    <= in_req.align_log2;
      free_off_r <= in_req.free_offset;
    end
    if (state_r == S_WAIT && tail_i.active) begin
      status_r <= tail_i.done ? tail_i.status : ST_NOT_FOUND;
      result_r <= (tail_i.done && tail_i.status == ST_OK) ? tail_i.result : '0;
    end
  end

  assign in_req.ready          = (state_r == S_IDLE);
  assign out_res.valid         = out_valid_r;
  assign out_res.status        = status_r;
  assign out_res.result_offset = result_r;

`ifndef NO_ASSERTIONS
  a_tail_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    tail_i.active |-> state_r == S_WAIT)
    else $error("walk token left the chain outside the wait state");

  a_out_from_wait: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_WAIT))
    else $error("result appeared without a finished walk");
`endif

endmodule

>>> sv/first_fit_aligned_region_allocator.sv
// First-fit aligned region allocator: controller plus a row of extent cells.
// Depends on ffa_pkg, the channel interfaces, ffa_ctrl and ffa_cell.
//
// Requests arrive on in_req (valid/ready): allocate req_size bytes aligned to
// 2^align_log2, or free the extent at free_offset of size req_size. Each
// request gives one result on out_res (valid/ready): status and, for a
// successful allocate, the offset of the new extent.
// The table is a row of MAX_EXTENTS cells, each holding one extent in offset
// order. A walk token enters the first cell and moves one cell per cycle,
// testing gaps, inserting or deleting as it goes, and always runs the full
// row. The result is registered once the token leaves the last cell, and
// only then is the next request taken: one request is walked at a time.
// A request is taken while an earlier result still waits; its walk starts
// only once the output register is free, so a stalled receiver holds the
// block after one queued request.
// Reset empties the table (all cells invalid) and sets region_size to 4096.
// The cfg_wr_en/cfg_wr_data port writes region_size; the user writes it only
// while the block is idle, and the block itself does not enforce this.
module first_fit_aligned_region_allocator (
  input  logic                            clk,
  input  logic                            rst_n,
  ffa_req_if.sink                         in_req,
  ffa_res_if.source                       out_res,
  input  logic                            cfg_wr_en,
  input  logic [ffa_pkg::REGION_BITS-1:0] cfg_wr_data
);
  import ffa_pkg::*;

  bcast_t                 bcast;
  pkt_t                   pkt_link   [MAX_EXTENTS+1];
  entry_t                 entry_link [MAX_EXTENTS+1];
  cell_stat_t             stat       [MAX_EXTENTS];
  logic [MAX_EXTENTS-1:0] valid_vec, tok_vec;

  assign entry_link[MAX_EXTENTS] = '0;

  ffa_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_req      (in_req),
    .out_res     (out_res),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .table_full  (valid_vec[MAX_EXTENTS-1]),
    .tail_i      (pkt_link[MAX_EXTENTS]),
    .launch_o    (pkt_link[0]),
    .bcast_o     (bcast)
  );

  for (genvar k = 0; k < MAX_EXTENTS; k++) begin : g_cell
    ffa_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .bcast   (bcast),
      .pkt_i   (pkt_link[k]),
      .pkt_o   (pkt_link[k+1]),
      .entry_i (entry_link[k+1]),
      .entry_o (entry_link[k]),
      .stat_o  (stat[k])
    );
    assign valid_vec[k] = stat[k].valid;
    assign tok_vec[k]   = stat[k].tok;
  end

`ifndef NO_ASSERTIONS
  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((valid_vec + MAX_EXTENTS'(1)) & valid_vec) == '0)
    else $error("occupied cells do not form a prefix of the row");

  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vec))
    else $error("more than one walk token in the cell row");
`endif

endmodule

>>> test/tb_first_fit_aligned_region_allocator.sv
// Testbench of first_fit_aligned_region_allocator: a directed table, then random phases at
// several region sizes, checked against typed rows or a local extent-table predictor.
// Depends on ffa_pkg, the channel interfaces in ffa_intf.sv and the allocator top level.
module tb_first_fit_aligned_region_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import ffa_pkg::*;

  localparam int    IDLE_PCT    = 27;
  localparam int    SETTLE      = 40;
  localparam int    HOLD_AT     = 700;
  localparam int    HOLD_CYCLES = 400;
  localparam int    QUIET_LIMIT = 4000;
  localparam longint SPAN       = longint'(1) << OFFSET_BITS;
  localparam int    N_DIR       = 30;
  localparam int    N_PHASES    = 9;
  localparam int    PHASE_ITEMS = 172;

  typedef enum logic [0:0] {
    ROW_REQ = 1'b0,
    ROW_CFG = 1'b1
  } row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    op_t                    op;
    logic [SIZE_BITS-1:0]   size;
    logic [ALIGN_BITS-1:0]  align;
    logic [OFFSET_BITS-1:0] off;
    logic                   typed;
    status_t                st;
    logic [OFFSET_BITS-1:0] res;
  } dir_row_t;

  typedef struct packed {
    status_t                st;
    logic [OFFSET_BITS-1:0] off;
  } alloc_result_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [REGION_BITS-1:0] cfg_wr_data;

  ffa_req_if req_ch ();
  ffa_res_if res_ch ();

  first_fit_aligned_region_allocator DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_req      (req_ch),
    .out_res     (res_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  logic [OFFSET_BITS-1:0] tbl_off  [MAX_EXTENTS];
  logic [SIZE_BITS-1:0]   tbl_size [MAX_EXTENTS];
  int                     tbl_count;
  logic [REGION_BITS-1:0] region_bytes;

  alloc_result_t pending_results [$];
  int  errors;
  int  results_seen;
  int  requests_sent;
  int  quiet_cycles;
  int  status_seen [4];
  int  regions_used;
  bit  no_idle;
  bit  held;

  dir_row_t dir_rows [N_DIR] = '{
    '{ROW_REQ, OP_FREE,  17'd0,      4'd0,  16'd0,     1'b1, ST_NOT_FOUND,  16'd0},
    '{ROW_REQ, OP_ALLOC, 17'd4097,   4'd0,  16'hFFFF,  1'b1, ST_NO_SPACE,   16'd0},
    '{ROW_REQ, OP_ALLOC, 17'd4096,   4'd0,  16'd0,     1'b1, ST_OK,         16'd0},
    '{ROW_REQ, OP_ALLOC, 17'd1,      4'd0,  16'd0,     1'b1, ST_NO_SPACE,   16'd0},
    '{ROW_REQ, OP_ALLOC, 17'd0,      4'd0,  16'd0,     1'b1, ST_OK,         16'd0},
    '{ROW_REQ, OP_ALLOC, 17'd0,      4'd15, 16'd0,     1'b1, ST_OK,         16'd0},
    '{ROW_REQ, OP_FREE,  17'd0,      4'd0,  16'd0,     1'b1, ST_OK,         16'd0},
    '{ROW_REQ, OP_FREE,  17'd0,      4'd15, 16'd0,     1'b1, ST_OK,         16'd0},
    '{ROW_REQ, OP_FREE,  17'd0,      4'd0,  16'd0,     1'b1, ST_NOT_FOUND,  16'd0},
    '{ROW_REQ, OP_FREE,  17'd4096,   4'd0,  16'd0,     1'b1, ST_OK,         16'd0},
    '{ROW_REQ, OP_ALLOC, 17'd1,      4'd0,  16'd0,     1'b1, ST_OK,         16'd0},
    '{ROW_REQ, OP_ALLOC, 17'd1,      4'd15, 16'd0,     1'b1, ST_NO_SPACE,   16'd0},
    '{ROW_REQ, OP_ALLOC, 17'd100,    4'd4,  16'd0,     1'b1, ST_OK,         16'd16},
    '{ROW_REQ, OP_ALLOC, 17'd8,      4'd0,  16'd0,     1'b0, ST_OK,         16'd0},
    '{ROW_REQ, OP_ALLOC, 17'h1FFFF,  4'd15, 16'd0,     1'b1, ST_NO_SPACE,   16'd0},
    '{ROW_REQ, OP_FREE,  17'h1FFFF,  4'd15, 16'hFFFF,  1'b1, ST_NOT_FOUND,  16'd0},
    '{ROW_REQ, OP_FREE,  17'd99,     4'd0,  16'd16,    1'b1, ST_NOT_FOUND,  16'd0},
    '{ROW_REQ, OP_FREE,  17'd100,    4'd0,  16'd16,    1'b1, ST_OK,         16'd0},
    '{ROW_REQ, OP_FREE,  17'd8,      4'd0,  16'd1,     1'b0, ST_OK,         16'd0},
    '{ROW_REQ, OP_FREE,  17'd1,      4'd0,  16'd0,     1'b1, ST_OK,         16'd0},
    '{ROW_CFG, OP_ALLOC, 17'h1FFFF,  4'd0,  16'd0,     1'b0, ST_OK,         16'd0},
    '{ROW_REQ, OP_ALLOC, 17'd65536,  4'd0,  16'd0,     1'b1, ST_OK,         16'd0},
    '{ROW_REQ, OP_ALLOC, 17'd1,      4'd0,  16'd0,     1'b1, ST_NO_SPACE,   16'd0},
    '{ROW_CFG, OP_ALLOC, 17'd4096,   4'd0,  16'd0,     1'b0, ST_OK,         16'd0},
    '{ROW_REQ, OP_ALLOC, 17'd1,      4'd0,  16'd0,     1'b1, ST_NO_SPACE,   16'd0},
    '{ROW_REQ, OP_FREE,  17'd65536,  4'd0,  16'd0,     1'b1, ST_OK,         16'd0},
    '{ROW_CFG, OP_ALLOC, 17'd0,      4'd0,  16'd0,     1'b0, ST_OK,         16'd0},
    '{ROW_REQ, OP_ALLOC, 17'd1,      4'd0,  16'd0,     1'b1, ST_NO_SPACE,   16'd0},
    '{ROW_REQ, OP_ALLOC, 17'd0,      4'd0,  16'd0,     1'b1, ST_OK,         16'd0},
    '{ROW_REQ, OP_FREE,  17'd0,      4'd0,  16'd0,     1'b1, ST_OK,         16'd0}
  };

  function automatic void open_slot(int pos, longint at, logic [SIZE_BITS-1:0] size);
    for (int k = tbl_count; k > pos; k--) begin
      tbl_off[k]  = tbl_off[k-1];
      tbl_size[k] = tbl_size[k-1];
    end
    tbl_off[pos]  = OFFSET_BITS'(at);
    tbl_size[pos] = size;
    tbl_count++;
  endfunction

  function automatic status_t place_extent(logic [SIZE_BITS-1:0] size,
                                           logic [ALIGN_BITS-1:0] align,
                                           output logic [OFFSET_BITS-1:0] at);
    longint mask;
    longint run;
    longint pad;
    longint start;
    longint lim;
    at = '0;
    if (tbl_count >= MAX_EXTENTS) return ST_TABLE_FULL;
    mask = (longint'(1) << align) - 1;
    run  = 0;
    for (int i = 0; i < tbl_count; i++) begin
      start = longint'(tbl_off[i]);
      pad   = (-run) & mask;
      if (start >= run && start - run >= longint'(size) + pad) begin
        if (run + pad >= SPAN) return ST_NO_SPACE;
        open_slot(i, run + pad, size);
        at = OFFSET_BITS'(run + pad);
        return ST_OK;
      end
      run = start + longint'(tbl_size[i]);
    end
    lim = (longint'(region_bytes) > SPAN) ? SPAN : longint'(region_bytes);
    pad = (-run) & mask;
    if (lim >= run && lim - run >= longint'(size) + pad) begin
      if (run + pad >= SPAN) return ST_NO_SPACE;
      open_slot(tbl_count, run + pad, size);
      at = OFFSET_BITS'(run + pad);
      return ST_OK;
    end
    return ST_NO_SPACE;
  endfunction

  function automatic status_t release_extent(logic [OFFSET_BITS-1:0] off,
                                             logic [SIZE_BITS-1:0] size);
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_off[i] == off && tbl_size[i] == size) begin
        for (int k = i; k + 1 < tbl_count; k++) begin
          tbl_off[k]  = tbl_off[k+1];
          tbl_size[k] = tbl_size[k+1];
        end
        tbl_count--;
        return ST_OK;
      end
    end
    return ST_NOT_FOUND;
  endfunction

  function automatic void flag_error(string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endfunction

  // Called just after a falling edge; returns just after the falling edge that
  // follows acceptance, with valid still high.
  task automatic push_request(op_t op, logic [SIZE_BITS-1:0] size,
                              logic [ALIGN_BITS-1:0] align, logic [OFFSET_BITS-1:0] off,
                              bit typed, alloc_result_t typed_res);
    alloc_result_t predicted;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.operation   <= op;
    req_ch.req_size    <= size;
    req_ch.align_log2  <= align;
    req_ch.free_offset <= off;
    do @(posedge clk); while (!req_ch.ready);
    predicted.off = '0;
    if (op == OP_ALLOC) predicted.st = place_extent(size, align, predicted.off);
    else predicted.st = release_extent(off, size);
    pending_results.push_back(typed ? typed_res : predicted);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic set_region(logic [REGION_BITS-1:0] value);
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en    <= 1'b0;
    region_bytes  = value;
    regions_used++;
  endtask

  task automatic run_phase(int n, int alloc_pct);
    op_t                    op;
    logic [SIZE_BITS-1:0]   size;
    logic [ALIGN_BITS-1:0]  align;
    logic [OFFSET_BITS-1:0] off;
    int                     pick;
    int                     roll;
    for (int j = 0; j < n; j++) begin
      align = ALIGN_BITS'($urandom_range(0, 15));
      off   = OFFSET_BITS'($urandom);
      roll  = $urandom_range(99);
      if ($urandom_range(99) < alloc_pct) begin
        op = OP_ALLOC;
        if (roll < 50) size = SIZE_BITS'($urandom_range(0, 16));
        else if (roll < 80) size = SIZE_BITS'($urandom_range(0, 256));
        else if (roll < 95) size = SIZE_BITS'($urandom_range(0, 4096));
        else size = SIZE_BITS'($urandom);
        roll = $urandom_range(99);
        if (roll < 60) align = ALIGN_BITS'($urandom_range(0, 4));
        else if (roll < 90) align = ALIGN_BITS'($urandom_range(0, 10));
      end else begin
        op = OP_FREE;
        if (tbl_count > 0 && roll < 80) begin
          pick = $urandom_range(0, tbl_count - 1);
          off  = tbl_off[pick];
          size = tbl_size[pick];
        end else if (tbl_count > 0 && roll < 90) begin
          pick = $urandom_range(0, tbl_count - 1);
          off  = tbl_off[pick];
          size = tbl_size[pick] + ($urandom_range(1) ? 17'd1 : 17'h1FFFF);
        end else begin
          size = SIZE_BITS'($urandom);
        end
      end
      push_request(op, size, align, off, 1'b0, '0);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    res_ch.ready = 1'b0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && results_seen >= HOLD_AT) begin
        held = 1'b1;
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      res_ch.ready <= rst_n && (no_idle || $urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    alloc_result_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        flag_error($sformatf("unexpected result: status %0d offset %0d",
                             res_ch.status, res_ch.result_offset));
      end else begin
        want = pending_results.pop_front();
        status_seen[want.st]++;
        if (res_ch.status !== want.st || res_ch.result_offset !== want.off) begin
          flag_error($sformatf("result %0d: expected status %0d offset %0d, got %0d %0d",
                               results_seen, want.st, want.off,
                               res_ch.status, res_ch.result_offset));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int              regions [N_PHASES];
    alloc_result_t   typed_res;
    rst_n              = 1'b0;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = '0;
    req_ch.valid       = 1'b0;
    req_ch.operation   = OP_ALLOC;
    req_ch.req_size    = '0;
    req_ch.align_log2  = '0;
    req_ch.free_offset = '0;
    errors        = 0;
    results_seen  = 0;
    requests_sent = 0;
    quiet_cycles  = 0;
    regions_used  = 1;
    no_idle       = 1'b0;
    status_seen   = '{default: 0};
    tbl_count     = 0;
    region_bytes  = REGION_RESET;
    regions = '{65536, 1, 131071, 4096, 300, 65535, 0, $urandom_range(1, 131071), 20000};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        set_region(dir_rows[r].size);
      end else begin
        typed_res.st  = dir_rows[r].st;
        typed_res.off = dir_rows[r].res;
        push_request(dir_rows[r].op, dir_rows[r].size, dir_rows[r].align, dir_rows[r].off,
                     dir_rows[r].typed, typed_res);
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      set_region(REGION_BITS'(regions[p]));
      no_idle = (p == 2);
      run_phase(PHASE_ITEMS, (p % 2 == 0) ? 70 : 50);
    end
    no_idle = 1'b0;

    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Covered %0d requests over %0d region settings, with one long result stall.",
             requests_sent, regions_used);
    $display("Statuses: ok %0d, no space %0d, table full %0d, not found %0d; %0d mismatches.",
             status_seen[ST_OK], status_seen[ST_NO_SPACE], status_seen[ST_TABLE_FULL],
             status_seen[ST_NOT_FOUND], errors);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/ffa_pkg.sv
sv/ffa_intf.sv
sv/ffa_cell.sv
sv/ffa_ctrl.sv
sv/first_fit_aligned_region_allocator.sv
test/tb_first_fit_aligned_region_allocator.sv
